// ===== hdl/ais_pkg.sv =====
// Package for the area-average image scaler: default sizes, field widths,
// register indexes and the input action codes. No dependencies.
package ais_pkg;

  localparam int MaxWidthDef  = 512;
  localparam int MaxHeightDef = 512;

  localparam int CoordW  = 9;   // load and destination coordinate fields
  localparam int SizeW   = 10;  // size registers
  localparam int PixelW  = 32;  // RGBA8 word
  localparam int CfgIdxW = 3;
  localparam int InDataW = 72;  // 68 payload bits padded to bytes
  localparam int OutDataW = 32;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_SRC_WIDTH  = 3'd0,
    REG_SRC_HEIGHT = 3'd1,
    REG_DST_WIDTH  = 3'd2,
    REG_DST_HEIGHT = 3'd3,
    REG_SCALE_MODE = 3'd4
  } cfg_reg_e;

  localparam logic ACT_LOAD    = 1'b0;
  localparam logic ACT_COMPUTE = 1'b1;
  localparam logic MODE_AREA    = 1'b0;
  localparam logic MODE_NEAREST = 1'b1;
  localparam logic ST_OK    = 1'b0;
  localparam logic ST_RANGE = 1'b1;

endpackage

// ===== hdl/ais_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module ais_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/ais_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
// No dependencies.
module ais_div #(
  parameter int Width = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [Width-1:0] num_i,
  input  logic [Width-1:0] den_i,
  output logic             done_o,
  output logic [Width-1:0] quo_o
);

  localparam int CntW = $clog2(Width + 1);

  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             done_q, done_d;
  logic [Width-1:0] rem_q, rem_d, quo_q, quo_d, den_q, den_d;
  logic [Width:0]   trial;

  // load on start, else one shift-subtract step
  always_comb begin
    cnt_d  = cnt_q;
    done_d = 1'b0;
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    trial  = {rem_q, quo_q[Width-1]};
    if (start_i) begin
      cnt_d = CntW'(Width);
      rem_d = '0;
      quo_d = num_i;
      den_d = den_i;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - 1'b1;
      if (trial >= {1'b0, den_q}) begin
        rem_d = Width'(trial - {1'b0, den_q});
        quo_d = {quo_q[Width-2:0], 1'b1};
      end else begin
        rem_d = trial[Width-1:0];
        quo_d = {quo_q[Width-2:0], 1'b0};
      end
      done_d = (cnt_q == CntW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

// ===== hdl/area_average_image_scaler_top.sv =====
// Top level of the area-average image scaler: config registers, frame store,
// footprint walker and divider sequencing. Uses ais_pkg, ais_ram, ais_div.
//
// channel   | dir | handshake                     | contents
// s_axis    | in  | tvalid/tready, tdata, tuser   | load pixel or compute request
// m_axis    | out | tvalid/tready, tdata, tuser   | destination color and status
// cfg       | in  | cfg_we_i, cfg_idx_i, cfg_data_i | size and mode registers
//
// A load word with coordinates inside the store is written as it is taken. A
// compute word runs setup and the footprint origin divides; nearest mode then reads
// one source pixel, area mode each covered source pixel in turn (one frame store
// read port) and then the channel divides and output. DivW = 8 + bits(MAX_WIDTH) +
// bits(MAX_HEIGHT). One compute word is worked at a time; s_axis_tready is low
// meanwhile. The output register lets the next word be taken while a result waits.
// Reset clears control and sets config to sizes of one and area mode; the frame store holds garbage until loaded.
module area_average_image_scaler_top
  import ais_pkg::*;
#(
  parameter int MAX_WIDTH  = MaxWidthDef,
  parameter int MAX_HEIGHT = MaxHeightDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // load_x, load_y, load_red, load_green, load_blue, load_alpha, out_x, out_y
  input  logic [InDataW-1:0]  s_axis_tdata,
  // action
  input  logic [0:0]          s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // out_red, out_green, out_blue, out_alpha
  output logic [OutDataW-1:0] m_axis_tdata,
  // status
  output logic [0:0]          m_axis_tuser,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [SizeW-1:0]    cfg_data_i
);

  localparam int XW    = $clog2(MAX_WIDTH + 1);
  localparam int YW    = $clog2(MAX_HEIGHT + 1);
  localparam int PXW   = XW + SizeW;
  localparam int PYW   = YW + SizeW;
  localparam int AccW  = 8 + XW + YW;
  localparam int DivW  = AccW;
  localparam int Depth = MAX_WIDTH * MAX_HEIGHT;
  localparam int RamAW = $clog2(Depth);

  typedef enum logic [3:0] {
    S_IDLE, S_SETUP, S_XS, S_XW, S_YS, S_YW, S_PREP,
    S_RD, S_WT, S_AC, S_NW, S_CS, S_CW, S_DONE
  } state_e;

  state_e state_q, state_d;

  // input fields
  logic [CoordW-1:0] in_lx, in_ly, in_dx, in_dy;
  logic [PixelW-1:0] in_pix;
  assign in_lx  = s_axis_tdata[8:0];
  assign in_ly  = s_axis_tdata[17:9];
  assign in_pix = s_axis_tdata[49:18];
  assign in_dx  = s_axis_tdata[58:50];
  assign in_dy  = s_axis_tdata[67:59];

  // configuration registers
  logic [SizeW-1:0] sw_cfg_q, sh_cfg_q, dw_cfg_q, dh_cfg_q;
  logic             mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sw_cfg_q <= SizeW'(1);
      sh_cfg_q <= SizeW'(1);
      dw_cfg_q <= SizeW'(1);
      dh_cfg_q <= SizeW'(1);
      mode_q   <= MODE_AREA;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_SRC_WIDTH:  sw_cfg_q <= cfg_data_i;
        REG_SRC_HEIGHT: sh_cfg_q <= cfg_data_i;
        REG_DST_WIDTH:  dw_cfg_q <= cfg_data_i;
        REG_DST_HEIGHT: dh_cfg_q <= cfg_data_i;
        REG_SCALE_MODE: mode_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // effective sizes: zero means one, source clipped to the store
  logic [XW-1:0]    sw;
  logic [YW-1:0]    sh;
  logic [SizeW-1:0] dw, dh;

  always_comb begin
    if (sw_cfg_q == '0) sw = XW'(1);
    else if (32'(sw_cfg_q) > MAX_WIDTH) sw = XW'(MAX_WIDTH);
    else sw = XW'(sw_cfg_q);
    if (sh_cfg_q == '0) sh = YW'(1);
    else if (32'(sh_cfg_q) > MAX_HEIGHT) sh = YW'(MAX_HEIGHT);
    else sh = YW'(sh_cfg_q);
    dw = (dw_cfg_q == '0) ? SizeW'(1) : dw_cfg_q;
    dh = (dh_cfg_q == '0) ? SizeW'(1) : dh_cfg_q;
  end

  // working registers
  logic [CoordW-1:0]   dx_q, dy_q;
  logic [PXW-1:0]      xa_q, xb_q, xlo_q, x0dw_q;
  logic [PYW-1:0]      ya_q, yb_q, ylo_q;
  logic [XW-1:0]       x_q, x0_q;
  logic [YW-1:0]       y_q;
  logic [XW+YW-1:0]    total_q;
  logic [SizeW-1:0]    wx_q, wy_q;
  logic [2*SizeW-1:0]  w_q;
  logic [AccW-1:0]     acc_q [4];
  logic [7:0]          col_q [4];
  logic                st_q;
  logic [1:0]          ch_q;

  // frame store
  logic              ram_we, ram_re;
  logic [RamAW-1:0]  ram_waddr, ram_raddr;
  logic [PixelW-1:0] ram_rdata;
  logic              s_fire, m_fire;

  assign s_fire    = s_axis_tvalid && s_axis_tready;
  assign m_fire    = m_axis_tvalid && m_axis_tready;
  assign ram_we    = s_fire && (s_axis_tuser[0] == ACT_LOAD) &&
                     (32'(in_lx) < MAX_WIDTH) && (32'(in_ly) < MAX_HEIGHT);
  assign ram_waddr = RamAW'(RamAW'(in_ly) * RamAW'(MAX_WIDTH) + RamAW'(in_lx));
  assign ram_re    = (state_q == S_RD) || (state_q == S_PREP);
  assign ram_raddr = RamAW'(RamAW'(y_q) * RamAW'(MAX_WIDTH) + RamAW'(x_q));

  ais_ram #(.Width(PixelW), .Depth(Depth)) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (in_pix),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // shared divider
  logic            div_start, div_done;
  logic [DivW-1:0] div_num, div_den, div_quo;

  always_comb begin
    div_start = 1'b0;
    div_num   = DivW'(acc_q[ch_q]);
    div_den   = DivW'(total_q);
    unique case (state_q)
      S_XS: begin
        div_start = 1'b1;
        div_num   = DivW'(xa_q);
        div_den   = DivW'(dw);
      end
      S_YS: begin
        div_start = 1'b1;
        div_num   = DivW'(ya_q);
        div_den   = DivW'(dh);
      end
      S_CS: div_start = 1'b1;
      default: ;
    endcase
  end

  ais_div #(.Width(DivW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // overlap of the current source pixel with the footprint
  logic [PXW-1:0] xhi, xend, xbeg;
  logic [PYW-1:0] yhi, yend, ybeg;
  logic           x_more, y_more;

  always_comb begin
    xhi    = xlo_q + PXW'(dw);
    yhi    = ylo_q + PYW'(dh);
    xend   = (xb_q < xhi) ? xb_q : xhi;
    xbeg   = (xa_q > xlo_q) ? xa_q : xlo_q;
    yend   = (yb_q < yhi) ? yb_q : yhi;
    ybeg   = (ya_q > ylo_q) ? ya_q : ylo_q;
    x_more = (xhi < xb_q) && ((x_q + 1'b1) < sw);
    y_more = (yhi < yb_q) && ((y_q + 1'b1) < sh);
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (s_fire && (s_axis_tuser[0] == ACT_COMPUTE)) begin
          if ((SizeW'(in_dx) >= dw) || (SizeW'(in_dy) >= dh)) state_d = S_DONE;
          else state_d = S_SETUP;
        end
      end
      S_SETUP: state_d = S_XS;
      S_XS:    state_d = S_XW;
      S_XW:    if (div_done) state_d = S_YS;
      S_YS:    state_d = S_YW;
      S_YW:    if (div_done) state_d = S_PREP;
      S_PREP:  state_d = (mode_q == MODE_NEAREST) ? S_NW : S_RD;
      S_RD:    state_d = S_WT;
      S_WT:    state_d = S_AC;
      S_AC:    state_d = (x_more || y_more) ? S_RD : S_CS;
      S_NW:    state_d = S_DONE;
      S_CS:    state_d = S_CW;
      S_CW: begin
        if (div_done) state_d = (ch_q == 2'd3) ? S_DONE : S_CS;
      end
      S_DONE:  if (!m_axis_tvalid || m_axis_tready) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // state, channel counter and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      m_axis_tvalid <= 1'b0;
      m_axis_tdata  <= '0;
      m_axis_tuser  <= '0;
      ch_q          <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == S_DONE && (!m_axis_tvalid || m_axis_tready)) begin
        m_axis_tvalid   <= 1'b1;
        m_axis_tdata    <= {col_q[3], col_q[2], col_q[1], col_q[0]};
        m_axis_tuser[0] <= st_q;
      end else if (m_fire) begin
        m_axis_tvalid <= 1'b0;
      end
      if (state_q == S_AC) ch_q <= '0;
      else if (state_q == S_CW && div_done) ch_q <= ch_q + 1'b1;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        dx_q <= in_dx;
        dy_q <= in_dy;
        st_q <= ST_RANGE;
        for (int c = 0; c < 4; c++) begin
          col_q[c] <= '0;
        end
      end
      S_SETUP: begin
        st_q    <= ST_OK;
        xa_q    <= PXW'(PXW'(dx_q) * PXW'(sw));
        xb_q    <= PXW'(PXW'({1'b0, dx_q} + 1'b1) * PXW'(sw));
        ya_q    <= PYW'(PYW'(dy_q) * PYW'(sh));
        yb_q    <= PYW'(PYW'({1'b0, dy_q} + 1'b1) * PYW'(sh));
        total_q <= (XW + YW)'(sw) * (XW + YW)'(sh);
        for (int c = 0; c < 4; c++) begin
          acc_q[c] <= '0;
        end
      end
      S_XW: begin
        if (div_done) begin
          x_q  <= XW'(div_quo);
          x0_q <= XW'(div_quo);
        end
      end
      S_YW: if (div_done) y_q <= YW'(div_quo);
      S_PREP: begin
        xlo_q  <= PXW'(PXW'(x_q) * PXW'(dw));
        x0dw_q <= PXW'(PXW'(x_q) * PXW'(dw));
        ylo_q  <= PYW'(PYW'(y_q) * PYW'(dh));
      end
      S_RD: begin
        wx_q <= SizeW'(xend - xbeg);
        wy_q <= SizeW'(yend - ybeg);
      end
      S_WT: w_q <= wx_q * wy_q;
      S_AC: begin
        for (int c = 0; c < 4; c++) begin
          acc_q[c] <= acc_q[c] + AccW'(ram_rdata[8*c +: 8]) * AccW'(w_q);
        end
        if (x_more) begin
          x_q   <= x_q + 1'b1;
          xlo_q <= xhi;
        end else begin
          x_q   <= x0_q;
          xlo_q <= x0dw_q;
          y_q   <= y_q + 1'b1;
          ylo_q <= yhi;
        end
      end
      S_NW: begin
        for (int c = 0; c < 4; c++) begin
          col_q[c] <= ram_rdata[8*c +: 8];
        end
      end
      S_CW: begin
        if (div_done) begin
          col_q[ch_q] <= (div_quo > DivW'(255)) ? 8'hFF : div_quo[7:0];
        end
      end
      default: ;
    endcase
  end

  assign s_axis_tready = (state_q == S_IDLE);

endmodule
